@@ design/stt_pkg.sv @@
package stt_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_COMMENT_BYTES_DEF = 4;
    localparam int POSITION_BITS_DEF     = 16;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Configuration register indexes
    localparam logic [1:0] CFG_EXT = 2'd0;
    localparam logic [1:0] CFG_PAT = 2'd1;
    localparam logic [1:0] CFG_LEN = 2'd2;

    // Token kinds
    localparam logic [4:0] K_IDENT  = 5'd0;
    localparam logic [4:0] K_INT    = 5'd1;
    localparam logic [4:0] K_LPAREN = 5'd2;
    localparam logic [4:0] K_RPAREN = 5'd3;
    localparam logic [4:0] K_LBRACE = 5'd4;
    localparam logic [4:0] K_RBRACE = 5'd5;
    localparam logic [4:0] K_COLON  = 5'd6;
    localparam logic [4:0] K_COMMA  = 5'd7;
    localparam logic [4:0] K_SEMI   = 5'd8;
    localparam logic [4:0] K_BANG   = 5'd9;
    localparam logic [4:0] K_EQ     = 5'd11;
    localparam logic [4:0] K_PLUS   = 5'd13;
    localparam logic [4:0] K_MINUS  = 5'd14;
    localparam logic [4:0] K_STAR   = 5'd15;
    localparam logic [4:0] K_SLASH  = 5'd16;
    localparam logic [4:0] K_DOT    = 5'd17;
    localparam logic [4:0] K_LT     = 5'd18;
    localparam logic [4:0] K_GT     = 5'd20;
    localparam logic [4:0] K_ERR    = 5'd22;
    localparam logic [4:0] K_END    = 5'd23;

    // Character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_US     = 8'h5F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;

    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_INT,
        M_BANG,
        M_EQ,
        M_LT,
        M_GT,
        M_MATCH,
        M_COMMENT
    } t_mode;

    typedef struct packed {
        logic        ext;
        logic [31:0] pat;
        logic [2:0]  clen;
    } t_cfg;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [7:0]  bad;
    } t_tok;

    typedef struct packed {
        logic emit;
        logic run_end;
        t_tok tok;
    } t_step;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } t_in;

    function automatic logic is_ws(logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    // Single-byte punctuation: hit flag over kind
    function automatic logic [5:0] punct_kind(logic [7:0] b);
        logic [5:0] r;
        case (b)
            CH_LPAREN: r = {1'b1, K_LPAREN};
            CH_RPAREN: r = {1'b1, K_RPAREN};
            CH_LBRACE: r = {1'b1, K_LBRACE};
            CH_RBRACE: r = {1'b1, K_RBRACE};
            CH_COLON:  r = {1'b1, K_COLON};
            CH_COMMA:  r = {1'b1, K_COMMA};
            CH_SEMI:   r = {1'b1, K_SEMI};
            CH_PLUS:   r = {1'b1, K_PLUS};
            CH_MINUS:  r = {1'b1, K_MINUS};
            CH_STAR:   r = {1'b1, K_STAR};
            CH_SLASH:  r = {1'b1, K_SLASH};
            CH_DOT:    r = {1'b1, K_DOT};
            default:   r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

@@ design/source_text_tokenizer_unit.sv @@
// Source text tokenizer.
// Input channel: one source byte per transfer (i_char_code), with
// i_end_of_source marking the final byte. Output channel: one token per
// transfer: kind, start position, length, offending byte for error tokens,
// and o_last_in_run on the last token caused by an input byte.
// Configuration: i_cfg_we writes register i_cfg_index (0 extended names,
// 1 comment pattern, 2 comment length) from i_cfg_data.
// Throughput: one byte per cycle while each byte needs one lexer step and
// the token queue has room. A byte that both ends a token and starts
// another takes two steps, and is slowed further when both steps give a
// token; a failed comment match replays its held bytes, one step per byte;
// the end of source takes one step per flushed token plus one for the end
// token. A token can be taken once it reaches the token queue; each further
// lexer step for the same byte (an earlier token, a replay, the flush) and
// each wait for the run to end delays it.
// Reset clears the queues, the lexer and the position counter to zero and
// the configuration registers to zero (comments off, plain names).
// When the receiver stalls, the two-entry token queue fills, the lexer
// halts and the two-entry input queue then drops o_in_ready.
module source_text_tokenizer_unit #(
    parameter int MAX_COMMENT_BYTES = stt_pkg::MAX_COMMENT_BYTES_DEF,
    parameter int POSITION_BITS     = stt_pkg::POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_source,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic [7:0]  o_bad_char,
    output logic        o_last_in_run
);
    import stt_pkg::*;

    t_cfg                     r_cfg;
    t_in                      q_item;
    logic                     q_valid, q_pop, go, step_valid;
    logic [POSITION_BITS-1:0] q_pos;
    t_step                    step;
    t_tok                     tok;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXT: r_cfg.ext  <= i_cfg_data[0];
                CFG_PAT: r_cfg.pat  <= i_cfg_data;
                CFG_LEN: r_cfg.clen <= i_cfg_data[2:0];
                default: r_cfg      <= r_cfg;
            endcase
        end
    end

    stt_front #(.PB(POSITION_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     ('{i_char_code, i_end_of_source}),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .o_q_pos    (q_pos),
        .i_q_pop    (q_pop)
    );

    stt_lexer #(.MCB(MAX_COMMENT_BYTES), .PB(POSITION_BITS)) u_lexer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .i_q_pos      (q_pos),
        .o_q_pop      (q_pop),
        .i_go         (go),
        .o_step_valid (step_valid),
        .o_step       (step)
    );

    stt_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_valid (step_valid),
        .i_step       (step),
        .o_go         (go),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_tok        (tok),
        .o_last       (o_last_in_run)
    );

    assign o_token_kind   = tok.kind;
    assign o_token_start  = tok.start;
    assign o_token_length = tok.len;
    assign o_bad_char     = tok.bad;

endmodule

@@ design/stt_front.sv @@
module stt_front #(
    parameter int PB = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  stt_pkg::t_in      i_item,
    output logic              o_q_valid,
    output stt_pkg::t_in      o_q_item,
    output logic [PB-1:0]     o_q_pos,
    input  logic              i_q_pop
);
    import stt_pkg::*;

    t_in           r_item [2];
    logic [PB-1:0] r_ipos [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic [PB-1:0] r_pos;
    logic          acc;

    assign o_in_ready = (r_cnt != 2'd2);
    assign acc        = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_item[r_rp];
    assign o_q_pos    = r_ipos[r_rp];

    // Advance pointers, count and source position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_pos <= '0;
        end else begin
            if (acc) begin
                r_wp <= ~r_wp;
                if (i_item.eos) begin
                    r_pos <= '0;
                end else if (r_pos != '1) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, i_q_pop};
        end
    end

    // Stamp each transfer with its position
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_item[r_wp] <= i_item;
            r_ipos[r_wp] <= r_pos;
        end
    end

endmodule

@@ design/stt_lexer.sv @@
module stt_lexer #(
    parameter int MCB = 4,
    parameter int PB  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stt_pkg::t_cfg     i_cfg,
    input  logic              i_q_valid,
    input  stt_pkg::t_in      i_q_item,
    input  logic [PB-1:0]     i_q_pos,
    output logic              o_q_pop,
    input  logic              i_go,
    output logic              o_step_valid,
    output stt_pkg::t_step    o_step
);
    import stt_pkg::*;

    localparam int IW = (MCB > 1) ? $clog2(MCB) : 1;
    localparam int CW = $clog2(MCB + 1);

    t_mode         r_mode, n_mode;
    logic [PB-1:0] r_pstart;
    logic [15:0]   r_plen;
    logic [7:0]    r_held_ch  [MCB];
    logic [PB-1:0] r_held_pos [MCB];
    logic [CW-1:0] r_hc;
    logic [7:0]    r_rb_ch    [MCB];
    logic [PB-1:0] r_rb_pos   [MCB];
    logic          r_rb_allow [MCB];
    logic [CW-1:0] r_rb_cnt;
    logic          r_eos;
    logic [PB-1:0] r_end_pos;

    logic          from_rb, from_q, eos_work, active, fire;
    logic [7:0]    x_ch;
    logic [PB-1:0] x_pos;
    logic          x_allow;
    logic [2:0]    n_eff;
    logic [7:0]    pat_cur;
    logic          match_next, last_hold;
    logic [5:0]    pk;
    t_mode         a_mode;
    logic          a_emit, a_consume, a_replay, a_len_inc, a_start;
    logic          a_hold, a_match_start, a_end, a_run_end;
    t_tok          a_tok;

    function automatic logic [4:0] op_kind(t_mode m);
        logic [4:0] k;
        case (m)
            M_BANG:  k = K_BANG;
            M_EQ:    k = K_EQ;
            M_LT:    k = K_LT;
            default: k = K_GT;
        endcase
        return k;
    endfunction

    // Pick the item: replay buffer first, then the input queue
    assign from_rb  = (r_rb_cnt != '0);
    assign eos_work = r_eos && !from_rb;
    assign from_q   = !from_rb && !r_eos && i_q_valid;
    assign active   = from_rb || from_q || eos_work;
    assign fire     = active && i_go;
    assign x_ch     = from_rb ? r_rb_ch[0] : i_q_item.ch;
    assign x_pos    = from_rb ? r_rb_pos[0] : i_q_pos;
    assign x_allow  = from_rb ? r_rb_allow[0] : 1'b1;

    assign o_step_valid = fire;
    assign o_q_pop      = fire && from_q;

    // Effective comment length
    always_comb begin
        n_eff = i_cfg.clen;
        if (int'(i_cfg.clen) > MCB) begin
            n_eff = 3'(MCB);
        end
        if (n_eff > 3'd4) begin
            n_eff = 3'd4;
        end
    end

    assign pat_cur    = 8'(i_cfg.pat >> {2'(r_hc), 3'b000});
    assign match_next = ({1'b0, r_hc} < 4'(n_eff)) && (x_ch == pat_cur);
    assign last_hold  = (4'(r_hc) + 4'd1) >= 4'(n_eff);
    assign pk         = punct_kind(x_ch);

    // Decode one step of the lexer
    always_comb begin
        a_emit        = 1'b0;
        a_tok         = '0;
        a_consume     = 1'b1;
        a_replay      = 1'b0;
        a_len_inc     = 1'b0;
        a_start       = 1'b0;
        a_hold        = 1'b0;
        a_match_start = 1'b0;
        a_end         = 1'b0;
        a_mode        = r_mode;
        if (eos_work) begin
            a_consume = 1'b0;
            a_mode    = M_IDLE;
            case (r_mode)
                M_MATCH: begin
                    a_replay = 1'b1;
                end
                M_IDENT: begin
                    a_emit = 1'b1;
                    a_tok  = '{K_IDENT, 16'(r_pstart), r_plen, 8'd0};
                end
                M_INT: begin
                    a_emit = 1'b1;
                    a_tok  = '{K_INT, 16'(r_pstart), r_plen, 8'd0};
                end
                M_BANG, M_EQ, M_LT, M_GT: begin
                    a_emit = 1'b1;
                    a_tok  = '{op_kind(r_mode), 16'(r_pstart), 16'd1, 8'd0};
                end
                default: begin
                    a_emit = 1'b1;
                    a_end  = 1'b1;
                    a_tok  = '{K_END, 16'(r_end_pos), 16'd0, 8'd0};
                end
            endcase
        end else begin
            case (r_mode)
                M_IDENT, M_INT: begin
                    if ((r_mode == M_INT) ? is_digit(x_ch) :
                        (i_cfg.ext ? !is_ws(x_ch) :
                         (is_alpha(x_ch) || is_digit(x_ch) || x_ch == CH_US))) begin
                        a_len_inc = 1'b1;
                    end else begin
                        a_emit    = 1'b1;
                        a_tok     = '{(r_mode == M_INT) ? K_INT : K_IDENT,
                                      16'(r_pstart), r_plen, 8'd0};
                        a_consume = 1'b0;
                        a_mode    = M_IDLE;
                    end
                end
                M_BANG, M_EQ, M_LT, M_GT: begin
                    a_emit = 1'b1;
                    a_mode = M_IDLE;
                    if (x_ch == CH_EQ) begin
                        a_tok = '{op_kind(r_mode) + 5'd1, 16'(r_pstart), 16'd2, 8'd0};
                    end else begin
                        a_tok     = '{op_kind(r_mode), 16'(r_pstart), 16'd1, 8'd0};
                        a_consume = 1'b0;
                    end
                end
                M_COMMENT: begin
                    if (x_ch == CH_NL) begin
                        a_mode = M_IDLE;
                    end
                end
                M_MATCH: begin
                    if (match_next) begin
                        a_hold = 1'b1;
                        if (last_hold) begin
                            a_mode = M_COMMENT;
                        end
                    end else begin
                        a_replay  = 1'b1;
                        a_consume = 1'b0;
                        a_mode    = M_IDLE;
                    end
                end
                default: begin
                    a_mode = M_IDLE;
                    if (is_ws(x_ch)) begin
                        a_mode = M_IDLE;
                    end else if (x_allow && n_eff != 3'd0 && x_ch == i_cfg.pat[7:0]) begin
                        if (n_eff == 3'd1) begin
                            a_mode = M_COMMENT;
                        end else begin
                            a_mode        = M_MATCH;
                            a_match_start = 1'b1;
                        end
                    end else begin
                        a_start = 1'b1;
                        if (is_alpha(x_ch)) begin
                            a_mode = M_IDENT;
                        end else if (is_digit(x_ch)) begin
                            a_mode = M_INT;
                        end else if (pk[5]) begin
                            a_emit = 1'b1;
                            a_tok  = '{pk[4:0], 16'(x_pos), 16'd1, 8'd0};
                        end else if (x_ch == CH_BANG) begin
                            a_mode = M_BANG;
                        end else if (x_ch == CH_EQ) begin
                            a_mode = M_EQ;
                        end else if (x_ch == CH_LT) begin
                            a_mode = M_LT;
                        end else if (x_ch == CH_GT) begin
                            a_mode = M_GT;
                        end else begin
                            a_emit = 1'b1;
                            a_tok  = '{K_ERR, 16'(x_pos), 16'd1, x_ch};
                        end
                    end
                end
            endcase
        end
    end

    // End of run: nothing left to do for the current input transfer
    always_comb begin
        if (eos_work) begin
            a_run_end = a_end;
        end else if (!a_consume) begin
            a_run_end = 1'b0;
        end else if (from_rb) begin
            a_run_end = (r_rb_cnt == CW'(1)) && !r_eos;
        end else begin
            a_run_end = !i_q_item.eos;
        end
    end

    assign o_step = '{a_emit, a_run_end, a_tok};

    // Next lexer mode
    always_comb begin
        n_mode = r_mode;
        if (fire) begin
            n_mode = a_mode;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_hc     <= '0;
            r_rb_cnt <= '0;
            r_eos    <= 1'b0;
        end else begin
            r_mode <= n_mode;
            if (fire) begin
                if (from_q && i_q_item.eos) begin
                    r_eos <= 1'b1;
                end
                if (a_end) begin
                    r_eos <= 1'b0;
                end
                if (a_match_start) begin
                    r_hc <= CW'(1);
                end else if (a_hold) begin
                    r_hc <= last_hold ? '0 : r_hc + 1'b1;
                end else if (a_replay || a_end) begin
                    r_hc <= '0;
                end
                if (a_replay) begin
                    if (eos_work) begin
                        r_rb_cnt <= r_hc;
                    end else if (from_q) begin
                        r_rb_cnt <= r_hc + 1'b1;
                    end else begin
                        r_rb_cnt <= r_hc + r_rb_cnt;
                    end
                end else if (from_rb) begin
                    if (a_consume) begin
                        r_rb_cnt <= r_rb_cnt - 1'b1;
                    end
                end else if (from_q && !a_consume) begin
                    r_rb_cnt <= CW'(1);
                end
            end
        end
    end

    // Payload: pending token, held bytes, replay buffer
    always_ff @(posedge i_clk) begin
        logic [IW-1:0] j;
        if (fire) begin
            if (from_q && i_q_item.eos) begin
                r_end_pos <= (i_q_pos == '1) ? i_q_pos : i_q_pos + 1'b1;
            end
            if (a_start) begin
                r_pstart <= x_pos;
                r_plen   <= 16'd1;
            end else if (a_match_start) begin
                r_pstart <= x_pos;
            end else if (a_len_inc && r_plen != LEN_MAX) begin
                r_plen <= r_plen + 16'd1;
            end
            if (a_match_start) begin
                r_held_ch[0]  <= x_ch;
                r_held_pos[0] <= x_pos;
            end else if (a_hold) begin
                r_held_ch[r_hc[IW-1:0]]  <= x_ch;
                r_held_pos[r_hc[IW-1:0]] <= x_pos;
            end
            if (a_replay) begin
                for (int i = 0; i < MCB; i++) begin
                    j = IW'(i - int'(r_hc));
                    if (i < int'(r_hc)) begin
                        r_rb_ch[i]    <= r_held_ch[i];
                        r_rb_pos[i]   <= r_held_pos[i];
                        r_rb_allow[i] <= (i != 0);
                    end else if (from_q) begin
                        r_rb_ch[i]    <= x_ch;
                        r_rb_pos[i]   <= x_pos;
                        r_rb_allow[i] <= 1'b1;
                    end else if (from_rb) begin
                        r_rb_ch[i]    <= r_rb_ch[j];
                        r_rb_pos[i]   <= r_rb_pos[j];
                        r_rb_allow[i] <= r_rb_allow[j];
                    end
                end
            end else if (from_rb) begin
                if (a_consume) begin
                    for (int i = 0; i < MCB - 1; i++) begin
                        r_rb_ch[i]    <= r_rb_ch[i+1];
                        r_rb_pos[i]   <= r_rb_pos[i+1];
                        r_rb_allow[i] <= r_rb_allow[i+1];
                    end
                end
            end else if (from_q && !a_consume) begin
                r_rb_ch[0]    <= x_ch;
                r_rb_pos[0]   <= x_pos;
                r_rb_allow[0] <= 1'b1;
            end
        end
    end

    // Replay buffer never overflows
    a_rb_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_rb_cnt) <= MCB)
        else $error("replay buffer overflow");

    // A partial comment match always holds bytes; a comment holds none
    a_match_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_MATCH) |-> (r_hc != '0))
        else $error("match without held bytes");

    a_comment_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_COMMENT) |-> (r_hc == '0))
        else $error("comment with held bytes");

    // The last byte of the source always arms the flush
    a_eos_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_item.eos) |=> r_eos)
        else $error("end of source lost");

endmodule

@@ design/stt_outq.sv @@
module stt_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step_valid,
    input  stt_pkg::t_step   i_step,
    output logic             o_go,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output stt_pkg::t_tok    o_tok,
    output logic             o_last
);
    import stt_pkg::*;

    t_tok       r_q_tok  [2];
    logic       r_q_last [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_tok       r_stg;
    logic       r_stg_v, r_stg_fin;
    logic       full, push, pop, push_last, stg_load, stg_clr, stg_fin_set;
    t_tok       push_tok;

    assign full        = (r_cnt == 2'd2);
    assign o_go        = !r_stg_fin && !full;
    assign o_out_valid = (r_cnt != 2'd0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_tok       = r_q_tok[r_rp];
    assign o_last      = r_q_last[r_rp];

    // Hold one token until its run is known to continue or end
    always_comb begin
        push        = 1'b0;
        push_tok    = r_stg;
        push_last   = 1'b0;
        stg_load    = 1'b0;
        stg_clr     = 1'b0;
        stg_fin_set = 1'b0;
        if (r_stg_fin) begin
            if (!full) begin
                push      = 1'b1;
                push_last = 1'b1;
                stg_clr   = 1'b1;
            end
        end else if (i_step_valid) begin
            if (i_step.emit) begin
                if (r_stg_v) begin
                    push        = 1'b1;
                    stg_load    = 1'b1;
                    stg_fin_set = i_step.run_end;
                end else if (i_step.run_end) begin
                    push      = 1'b1;
                    push_tok  = i_step.tok;
                    push_last = 1'b1;
                end else begin
                    stg_load = 1'b1;
                end
            end else if (i_step.run_end && r_stg_v) begin
                push      = 1'b1;
                push_last = 1'b1;
                stg_clr   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_cnt     <= 2'd0;
            r_stg_v   <= 1'b0;
            r_stg_fin <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (stg_load) begin
                r_stg_v   <= 1'b1;
                r_stg_fin <= stg_fin_set;
            end else if (stg_clr) begin
                r_stg_v   <= 1'b0;
                r_stg_fin <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_tok[r_wp]  <= push_tok;
            r_q_last[r_wp] <= push_last;
        end
        if (stg_load) begin
            r_stg <= i_step.tok;
        end
    end

endmodule
